// File: design/assert_macros.svh
// assert_macros.svh: assertion macros shared by the single-wire bus master RTL
// depends on nothing; included by the modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SWBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/swbm_pkg.sv
// swbm_pkg: types, codes and constants of the single-wire bus master
// depends on nothing; imported by every other design file except assert_macros.svh
`default_nettype none

package swbm_pkg;

   localparam int TICK_W    = 10;
   localparam int BYTE_W    = 8;
   localparam int MODE_W    = 2;
   localparam int BIT_IDX_W = 3;
   localparam int REG_IDX_W = 3;

   // command codes
   localparam logic [MODE_W-1:0] CMD_RESET = 2'd0;
   localparam logic [MODE_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] CMD_READ  = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RESET_RECOV  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WR1_LOW      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WR1_HIGH     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WR0_LOW      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_WR0_HIGH     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_READ_LOW     = 3'd7;

   // register reset values
   localparam logic [TICK_W-1:0] RST_RESET_LOW   = 10'd480;
   localparam logic [TICK_W-1:0] RST_PRES_SAMPLE = 10'd70;
   localparam logic [TICK_W-1:0] RST_RESET_RECOV = 10'd410;
   localparam logic [TICK_W-1:0] RST_WR1_LOW     = 10'd6;
   localparam logic [TICK_W-1:0] RST_WR1_HIGH    = 10'd64;
   localparam logic [TICK_W-1:0] RST_WR0_LOW     = 10'd60;
   localparam logic [TICK_W-1:0] RST_WR0_HIGH    = 10'd10;
   localparam logic [TICK_W-1:0] RST_READ_LOW    = 10'd6;

   // fixed read slot timing
   localparam logic [TICK_W-1:0] READ_SAMPLE_DELAY = 10'd9;
   localparam logic [TICK_W-1:0] READ_SLOT_REST    = 10'd55;

   typedef enum logic [8:0] {
      PH_IDLE      = 9'b000000001,
      PH_RST_LOW   = 9'b000000010,
      PH_RST_WAIT  = 9'b000000100,
      PH_RST_RECOV = 9'b000001000,
      PH_WR_LOW    = 9'b000010000,
      PH_WR_HIGH   = 9'b000100000,
      PH_RD_LOW    = 9'b001000000,
      PH_RD_WAIT   = 9'b010000000,
      PH_RD_REST   = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low_time;
      logic [TICK_W-1:0] presence_sample_time;
      logic [TICK_W-1:0] reset_recovery_time;
      logic [TICK_W-1:0] write_one_low_time;
      logic [TICK_W-1:0] write_one_high_time;
      logic [TICK_W-1:0] write_zero_low_time;
      logic [TICK_W-1:0] write_zero_high_time;
      logic [TICK_W-1:0] read_low_time;
   } cfg_type;

   typedef struct packed {
      logic              line_level;
      logic              start_req;
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] write_byte;
   } req_word_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              presence;
      logic              idle_fault;
      logic [BYTE_W-1:0] read_byte;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: design/swbm_ifs.sv
// swbm_ifs: valid/ready channel interfaces for request and response words
// depends on swbm_pkg for field widths
`default_nettype none

interface swbm_req_if import swbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              line_level;
   logic              start_req;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] write_byte;

   modport source (output valid, output line_level, output start_req, output mode,
                   output write_byte, input ready);
   modport sink   (input valid, input line_level, input start_req, input mode,
                   input write_byte, output ready);
endinterface

interface swbm_rsp_if import swbm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              drive_low;
   logic              busy_res;
   logic              done_res;
   logic              presence;
   logic              idle_fault;
   logic [BYTE_W-1:0] read_byte;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output idle_fault, output read_byte, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input idle_fault, input read_byte, output ready);
endinterface

`default_nettype wire

// File: design/swbm_cfg.sv
// swbm_cfg: timing register file of the single-wire bus master
// depends on swbm_pkg for register indexes and reset values
`default_nettype none

module swbm_cfg import swbm_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RESET_LOW:   cfg_in.reset_low_time       = csr_wdata;
            REG_PRES_SAMPLE: cfg_in.presence_sample_time = csr_wdata;
            REG_RESET_RECOV: cfg_in.reset_recovery_time  = csr_wdata;
            REG_WR1_LOW:     cfg_in.write_one_low_time   = csr_wdata;
            REG_WR1_HIGH:    cfg_in.write_one_high_time  = csr_wdata;
            REG_WR0_LOW:     cfg_in.write_zero_low_time  = csr_wdata;
            REG_WR0_HIGH:    cfg_in.write_zero_high_time = csr_wdata;
            REG_READ_LOW:    cfg_in.read_low_time        = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time       <= RST_RESET_LOW;
         cfg_ff.presence_sample_time <= RST_PRES_SAMPLE;
         cfg_ff.reset_recovery_time  <= RST_RESET_RECOV;
         cfg_ff.write_one_low_time   <= RST_WR1_LOW;
         cfg_ff.write_one_high_time  <= RST_WR1_HIGH;
         cfg_ff.write_zero_low_time  <= RST_WR0_LOW;
         cfg_ff.write_zero_high_time <= RST_WR0_HIGH;
         cfg_ff.read_low_time        <= RST_READ_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/swbm_step.sv
// swbm_step: bus sequencer state and the per-tick next-state and result logic
// depends on swbm_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module swbm_step import swbm_pkg::*; #(
   parameter logic [TICK_W-1:0] SAMPLE_DELAY = READ_SAMPLE_DELAY,
   parameter logic [TICK_W-1:0] SLOT_REST    = READ_SLOT_REST
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire req_word_type  word,
   input  wire cfg_type       cfg,
   output rsp_word_type       result
);

   phase_type             phase_ff, phase_in;
   logic [TICK_W-1:0]     timer_ff, timer_in;
   logic [BIT_IDX_W-1:0]  bit_ff, bit_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;
   logic                  pres_ff, pres_in;

   logic [BIT_IDX_W-1:0]  bit_next;
   logic                  expired;
   logic                  done, fault, pres_out;
   logic [BYTE_W-1:0]     rbyte_out;

   assign bit_next = bit_ff + 3'd1;
   assign expired  = (timer_ff <= 10'd1);

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      pres_in   = pres_ff;
      done      = 1'b0;
      fault     = 1'b0;
      pres_out  = 1'b0;
      rbyte_out = '0;
      if (phase_ff == PH_IDLE) begin
         if (word.start_req) begin
            unique case (word.mode)
               CMD_RESET: begin
                  pres_in = 1'b0;
                  if (!word.line_level) begin
                     done  = 1'b1;
                     fault = 1'b1;
                  end else begin
                     phase_in = PH_RST_LOW;
                     timer_in = cfg.reset_low_time;
                  end
               end
               CMD_WRITE: begin
                  shift_in = word.write_byte;
                  bit_in   = '0;
                  phase_in = PH_WR_LOW;
                  timer_in = word.write_byte[0] ? cfg.write_one_low_time
                                                : cfg.write_zero_low_time;
               end
               CMD_READ: begin
                  shift_in = '0;
                  bit_in   = '0;
                  phase_in = PH_RD_LOW;
                  timer_in = cfg.read_low_time;
               end
               // unused mode leaves the master idle
               default: ;
            endcase
         end
      end else if (!expired) begin
         timer_in = timer_ff - 10'd1;
      end else begin
         unique case (phase_ff)
            PH_RST_LOW: begin
               phase_in = PH_RST_WAIT;
               timer_in = cfg.presence_sample_time;
            end
            PH_RST_WAIT: begin
               pres_in  = !word.line_level;
               phase_in = PH_RST_RECOV;
               timer_in = cfg.reset_recovery_time;
            end
            PH_RST_RECOV: begin
               // a line still held low after recovery voids the presence
               pres_out = pres_ff & word.line_level;
               pres_in  = pres_out;
               phase_in = PH_IDLE;
               timer_in = '0;
               done     = 1'b1;
            end
            PH_WR_LOW: begin
               phase_in = PH_WR_HIGH;
               timer_in = shift_ff[bit_ff] ? cfg.write_one_high_time
                                           : cfg.write_zero_high_time;
            end
            PH_WR_HIGH: begin
               if (bit_ff == 3'd7) begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
                  done     = 1'b1;
               end else begin
                  bit_in   = bit_next;
                  phase_in = PH_WR_LOW;
                  timer_in = shift_ff[bit_next] ? cfg.write_one_low_time
                                                : cfg.write_zero_low_time;
               end
            end
            PH_RD_LOW: begin
               phase_in = PH_RD_WAIT;
               timer_in = SAMPLE_DELAY;
            end
            PH_RD_WAIT: begin
               if (word.line_level) shift_in[bit_ff] = 1'b1;
               phase_in = PH_RD_REST;
               timer_in = SLOT_REST;
            end
            PH_RD_REST: begin
               if (bit_ff == 3'd7) begin
                  phase_in  = PH_IDLE;
                  timer_in  = '0;
                  done      = 1'b1;
                  rbyte_out = shift_ff;
               end else begin
                  bit_in   = bit_next;
                  phase_in = PH_RD_LOW;
                  timer_in = cfg.read_low_time;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               timer_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
      end
   end

   always_comb begin
      result.drive_low  = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                          (phase_in == PH_RD_LOW);
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.presence   = pres_out;
      result.idle_fault = fault;
      result.read_byte  = rbyte_out;
   end

   `SWBM_ASSERT_NEXT(a_fault_stays_idle, clock, reset,
      step_en && phase_ff == PH_IDLE && word.start_req && word.mode == CMD_RESET &&
      !word.line_level,
      phase_ff == PH_IDLE, "reset refused on low idle line but sequencer left idle")
   `SWBM_ASSERT_NEXT(a_timer_counts_down, clock, reset,
      step_en && phase_ff != PH_IDLE && timer_ff > 10'd1,
      timer_ff == $past(timer_ff) - 10'd1 && phase_ff == $past(phase_ff),
      "phase timer did not count down by one")

endmodule

`default_nettype wire

// File: design/single_wire_bus_master.sv
// single_wire_bus_master: top level with input and result registers around the sequencer
// depends on swbm_pkg, swbm_ifs, swbm_cfg, swbm_step and assert_macros.svh
//
// Usage: each request word is one microsecond tick. It carries the sampled bus
// level and, while the master is idle, an optional command (reset, write byte,
// read byte). Every request word yields exactly one response word that holds
// the pull-down drive for the coming tick, busy, done and the command results.
// Timing registers are written through the csr_ port; the user must do so only while no
// tick is in flight, which the block itself does not enforce. A request word passes
// the input register, then the result register, before its response word is valid.
// Throughput: one tick per cycle while the receiver takes responses, since the sequencer
// handles a tick with one pass of next-state logic between the two registers. A new
// request is taken while a finished response still waits.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle and loads the default timing values.
// When the receiver stalls, the response register holds its word, the input
// register holds one more, and the request side is then back-pressured.
`default_nettype none

`include "assert_macros.svh"

module single_wire_bus_master import swbm_pkg::*; #(
   parameter logic [TICK_W-1:0] SAMPLE_DELAY = READ_SAMPLE_DELAY,
   parameter logic [TICK_W-1:0] SLOT_REST    = READ_SLOT_REST
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   swbm_req_if.sink                  req_ch,
   swbm_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wdata
);

   cfg_type      cfg;
   req_word_type in_word_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type step_result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         req_take;

   swbm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swbm_step #(
      .SAMPLE_DELAY (SAMPLE_DELAY),
      .SLOT_REST    (SLOT_REST)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .word    (in_word_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // a word moves into the result register when that register is free or drains
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.line_level <= req_ch.line_level;
         in_word_ff.start_req  <= req_ch.start_req;
         in_word_ff.mode       <= req_ch.mode;
         in_word_ff.write_byte <= req_ch.write_byte;
      end
      if (advance) rsp_word_ff <= step_result;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.drive_low  = rsp_word_ff.drive_low;
   assign rsp_ch.busy_res   = rsp_word_ff.busy_res;
   assign rsp_ch.done_res   = rsp_word_ff.done_res;
   assign rsp_ch.presence   = rsp_word_ff.presence;
   assign rsp_ch.idle_fault = rsp_word_ff.idle_fault;
   assign rsp_ch.read_byte  = rsp_word_ff.read_byte;

   `SWBM_ASSERT_NEXT(a_held_word_kept, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff),
      "input word lost while result register was stalled")
   `SWBM_ASSERT_IMPL(a_done_not_busy, clock, reset,
      rsp_valid_ff && rsp_word_ff.done_res, !rsp_word_ff.busy_res && !rsp_word_ff.drive_low,
      "done word reports the bus still busy")

endmodule

`default_nettype wire

// File: dv/single_wire_bus_master_tb.sv
// single_wire_bus_master_tb: self-checking bench for the single-wire bus master
// every request word is one bus tick; each tick's response word is predicted and compared
// depends on swbm_pkg and swbm_ifs from the design folder
module single_wire_bus_master_tb import swbm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] CMD_UNUSED = 2'd3;
   localparam int LONG_HOLD = 40;
   localparam int DRAIN_BATCH = 48;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_wdata = '0;

   logic         drv_valid = 1'b0;
   req_word_type drv_word = '0;
   logic         rsp_ready = 1'b0;

   swbm_req_if req_if ();
   swbm_rsp_if rsp_if ();

   assign req_if.valid      = drv_valid;
   assign req_if.line_level = drv_word.line_level;
   assign req_if.start_req  = drv_word.start_req;
   assign req_if.mode       = drv_word.mode;
   assign req_if.write_byte = drv_word.write_byte;
   assign rsp_if.ready      = rsp_ready;

   single_wire_bus_master DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bus master state as the bench sees it
   phase_type         bus_phase = PH_IDLE;
   logic [TICK_W-1:0] slot_timer = '0;
   logic [2:0]        bit_pos = '0;
   logic [BYTE_W-1:0] data_shift = '0;
   logic              found_device = 1'b0;
   logic [TICK_W-1:0] timing [8] = '{RST_RESET_LOW, RST_PRES_SAMPLE, RST_RESET_RECOV,
                                     RST_WR1_LOW, RST_WR1_HIGH, RST_WR0_LOW,
                                     RST_WR0_HIGH, RST_READ_LOW};

   req_word_type ticks_to_send [$];
   rsp_word_type due_words [$];
   logic [MODE_W-1:0] cmd_pool [3] = '{CMD_RESET, CMD_WRITE, CMD_READ};

   int errors = 0;
   bit calm = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int gap_left = 0;
   int hold_left = 0;

   function automatic void enter_phase(phase_type p, logic [TICK_W-1:0] n);
      bus_phase = p;
      slot_timer = n;
   endfunction

   function automatic void start_write_slot();
      enter_phase(PH_WR_LOW, data_shift[bit_pos] ? timing[REG_WR1_LOW] : timing[REG_WR0_LOW]);
   endfunction

   // one tick of the sequencer; returns the response word it yields
   function automatic rsp_word_type tick_bus(req_word_type t);
      rsp_word_type r;
      r = '0;
      if (bus_phase == PH_IDLE) begin
         if (t.start_req) begin
            case (t.mode)
               CMD_RESET: begin
                  found_device = 1'b0;
                  if (!t.line_level) begin
                     r.done_res = 1'b1;
                     r.idle_fault = 1'b1;
                  end else begin
                     enter_phase(PH_RST_LOW, timing[REG_RESET_LOW]);
                  end
               end
               CMD_WRITE: begin
                  data_shift = t.write_byte;
                  bit_pos = '0;
                  start_write_slot();
               end
               CMD_READ: begin
                  data_shift = '0;
                  bit_pos = '0;
                  enter_phase(PH_RD_LOW, timing[REG_READ_LOW]);
               end
               default: ;
            endcase
         end
      end else if (slot_timer > 1) begin
         slot_timer = slot_timer - 1'b1;
      end else begin
         // a count of zero expires like a count of one
         case (bus_phase)
            PH_RST_LOW: enter_phase(PH_RST_WAIT, timing[REG_PRES_SAMPLE]);
            PH_RST_WAIT: begin
               found_device = !t.line_level;
               enter_phase(PH_RST_RECOV, timing[REG_RESET_RECOV]);
            end
            PH_RST_RECOV: begin
               // line stuck low after recovery means no valid answer
               if (!t.line_level) found_device = 1'b0;
               enter_phase(PH_IDLE, '0);
               r.done_res = 1'b1;
               r.presence = found_device;
            end
            PH_WR_LOW: enter_phase(PH_WR_HIGH, data_shift[bit_pos] ? timing[REG_WR1_HIGH]
                                                                   : timing[REG_WR0_HIGH]);
            PH_WR_HIGH: begin
               if (bit_pos == 3'd7) begin
                  enter_phase(PH_IDLE, '0);
                  r.done_res = 1'b1;
               end else begin
                  bit_pos = bit_pos + 1'b1;
                  start_write_slot();
               end
            end
            PH_RD_LOW: enter_phase(PH_RD_WAIT, READ_SAMPLE_DELAY);
            PH_RD_WAIT: begin
               if (t.line_level) data_shift[bit_pos] = 1'b1;
               enter_phase(PH_RD_REST, READ_SLOT_REST);
            end
            PH_RD_REST: begin
               if (bit_pos == 3'd7) begin
                  enter_phase(PH_IDLE, '0);
                  r.done_res = 1'b1;
                  r.read_byte = data_shift;
               end else begin
                  bit_pos = bit_pos + 1'b1;
                  enter_phase(PH_RD_LOW, timing[REG_READ_LOW]);
               end
            end
            default: enter_phase(PH_IDLE, '0);
         endcase
      end
      r.drive_low = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                    (bus_phase == PH_RD_LOW);
      r.busy_res = (bus_phase != PH_IDLE);
      return r;
   endfunction

   // request side: offers queued ticks, predicts each accepted one
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (drv_valid && req_if.ready) due_words.push_back(tick_bus(drv_word));
         if (!drv_valid || req_if.ready) begin
            if (gap_left == 0 && !calm && ticks_to_send.size() > 0 && $urandom_range(0, 6) == 0)
               gap_left = $urandom_range(1, 3);
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (ticks_to_send.size() > 0) begin
               drv_word <= ticks_to_send.pop_front();
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(string name, logic [BYTE_W-1:0] exp, logic [BYTE_W-1:0] act);
      if (act !== exp) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp, act);
         errors++;
      end
   endtask

   // response side: random stalls, one long hold on request, word checks
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               $error("response word with no prediction pending");
               errors++;
            end else begin
               want = due_words.pop_front();
               compare_field("drive_low", want.drive_low, rsp_if.drive_low);
               compare_field("busy_res", want.busy_res, rsp_if.busy_res);
               compare_field("done_res", want.done_res, rsp_if.done_res);
               compare_field("presence", want.presence, rsp_if.presence);
               compare_field("idle_fault", want.idle_fault, rsp_if.idle_fault);
               compare_field("read_byte", want.read_byte, rsp_if.read_byte);
            end
         end
         if (hold_left == 0) begin
            if (holds_served != hold_requests) begin
               holds_served++;
               hold_left = LONG_HOLD;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               hold_left = $urandom_range(1, 3);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_tick(logic lvl, logic go, logic [MODE_W-1:0] m, logic [BYTE_W-1:0] b);
      req_word_type w;
      w.line_level = lvl;
      w.start_req = go;
      w.mode = m;
      w.write_byte = b;
      ticks_to_send.push_back(w);
   endtask

   // ticks without a start; lvl below zero means a random line
   task automatic hold_ticks(int n, int lvl);
      repeat (n) begin
         push_tick(lvl < 0 ? 1'($urandom_range(0, 1)) : 1'(lvl), 1'b0,
                   MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (ticks_to_send.size() != 0 || due_words.size() != 0 || drv_valid);
   endtask

   // run the bus until the master is idle with nothing in flight
   task automatic settle_bus();
      wait_quiet();
      while (bus_phase != PH_IDLE) begin
         hold_ticks(DRAIN_BATCH, -1);
         wait_quiet();
      end
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      timing[idx] = val;
   endtask

   task automatic load_timing(cfg_type c);
      write_reg(REG_RESET_LOW, c.reset_low_time);
      write_reg(REG_PRES_SAMPLE, c.presence_sample_time);
      write_reg(REG_RESET_RECOV, c.reset_recovery_time);
      write_reg(REG_WR1_LOW, c.write_one_low_time);
      write_reg(REG_WR1_HIGH, c.write_one_high_time);
      write_reg(REG_WR0_LOW, c.write_zero_low_time);
      write_reg(REG_WR0_HIGH, c.write_zero_high_time);
      write_reg(REG_READ_LOW, c.read_low_time);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic cfg_type random_timing(int unsigned top);
      cfg_type c;
      c.reset_low_time = TICK_W'($urandom_range(1, top));
      c.presence_sample_time = TICK_W'($urandom_range(1, top));
      c.reset_recovery_time = TICK_W'($urandom_range(1, top));
      c.write_one_low_time = TICK_W'($urandom_range(1, top));
      c.write_one_high_time = TICK_W'($urandom_range(1, top));
      c.write_zero_low_time = TICK_W'($urandom_range(1, top));
      c.write_zero_high_time = TICK_W'($urandom_range(1, top));
      c.read_low_time = TICK_W'($urandom_range(1, top));
      return c;
   endfunction

   // mostly real command codes, some unused-mode; start set on a third of ticks; line mostly high
   task automatic random_traffic(int n);
      repeat (n) begin
         logic [MODE_W-1:0] m;
         m = ($urandom_range(0, 9) == 0) ? CMD_UNUSED : cmd_pool[$urandom_range(0, 2)];
         push_tick($urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0, m,
                   BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      do @(negedge clock);
      while (reset);

      // default timing: no start, refused reset, unused mode, no start, then one full write
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b1, CMD_RESET, 8'hFF);
      push_tick(1'b1, 1'b1, CMD_UNUSED, 8'h00);
      push_tick(1'b1, 1'b0, CMD_WRITE, 8'hFF);
      push_tick(1'b1, 1'b0, CMD_READ, 8'h00);
      push_tick(1'b1, 1'b1, CMD_WRITE, 8'h5A);
      // starts while busy are dropped
      push_tick(1'b0, 1'b1, CMD_WRITE, 8'hA5);
      push_tick(1'b1, 1'b1, CMD_READ, 8'h5A);
      push_tick(1'b1, 1'b1, CMD_RESET, 8'h00);
      settle_bus();

      // shortest slots
      load_timing('{default: TICK_W'(1)});
      push_tick(1'b1, 1'b1, CMD_WRITE, 8'h00);
      settle_bus();
      push_tick(1'b1, 1'b1, CMD_WRITE, 8'hFF);
      settle_bus();
      // read slots sample a random line while draining
      push_tick(1'b1, 1'b1, CMD_READ, 8'h00);
      settle_bus();
      // device answers and line recovers
      push_tick(1'b1, 1'b1, CMD_RESET, 8'h00);
      push_tick(1'b1, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b1, 1'b0, CMD_RESET, 8'h00);
      // answer, but the line stays low through recovery
      push_tick(1'b1, 1'b1, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      settle_bus();

      // zero counts behave as one tick
      load_timing('0);
      push_tick(1'b1, 1'b1, CMD_WRITE, 8'h3C);
      settle_bus();
      push_tick(1'b1, 1'b1, CMD_RESET, 8'h00);
      push_tick(1'b1, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b0, 1'b0, CMD_RESET, 8'h00);
      push_tick(1'b1, 1'b0, CMD_RESET, 8'h00);
      settle_bus();

      // random timing with one long receiver hold
      load_timing(random_timing(40));
      random_traffic(60);
      hold_requests++;
      settle_bus();

      // closing stretch without idling
      load_timing(random_timing(8));
      calm = 1'b1;
      random_traffic(60);
      settle_bus();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("single_wire_bus_master_tb OK");
      else
         $display("single_wire_bus_master_tb NOT OK");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("single_wire_bus_master_tb NOT OK");
      $finish;
   end

endmodule
